### hdl/hkv_pkg.sv
// Shared types, constants and defaults of the hashed key-value table.
package hkv_pkg;

   // Default geometry of the table.
   localparam int BUCKETS_DEFAULT = 64;
   localparam int WAYS_DEFAULT    = 4;

   // Mixer constants.
   localparam logic [31:0] MIX_MUL   = 32'h045d_9f3b;
   localparam int          MIX_SHIFT = 16;

   // Width of the entry count on the result side.
   localparam int COUNT_WIDTH = 9;

   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_PUT    = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [63:0] lookup_key;
      logic [63:0] store_value;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [63:0]            read_value;
      logic                   bucket_overflow;
      logic [COUNT_WIDTH-1:0] live_entries;
      logic                   sticky_failure;
   } rsp_type;

   // Controls of the shared mixer multiplier.
   typedef struct packed {
      logic load;
      logic mul_lo;
      logic mul_hi;
   } mix_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_READ,
      ST_MATCH,
      ST_CLEAR,
      ST_RESP
   } state_type;

endpackage

### hdl/hkv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hkv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/hkv_mix.sv
// Key mixer built around one shared 32 by 32 bit multiplier.
module hkv_mix (
   input  logic                clock,
   input  hkv_pkg::mix_ctl_type ctl,
   input  logic [63:0]         key,
   output logic [63:0]         mixed
);
   import hkv_pkg::*;

   logic [63:0] x_ff, x_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] shifted;
   logic [31:0] operand;
   logic [63:0] prod_full;

   // The xor-shift step feeds the multiplier one half at a time.
   always_comb begin
      shifted   = x_ff ^ (x_ff >> MIX_SHIFT);
      operand   = ctl.mul_hi ? shifted[63:32] : shifted[31:0];
      prod_full = operand * MIX_MUL;
      x_in      = x_ff;
      prod_in   = prod_ff;
      if (ctl.load) begin
         x_in = key;
      end else if (ctl.mul_lo) begin
         prod_in = prod_full;
      end else if (ctl.mul_hi) begin
         x_in = prod_ff + {prod_full[31:0], 32'h0};
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      prod_ff <= prod_in;
   end

   // The final xor-shift is left to the user, who needs only a few bits.
   assign mixed = x_ff;
endmodule

### hdl/hashed_key_value_table_unit.sv
// Top level of the hashed key-value table: sequencer, bucket match and stores.
//
// A lookup, put or remove request goes from acceptance to the result
// register through four passes through the one shared 32 by 32 bit
// multiplier of the key mixer, the bucket row read, compare and
// write-back, and the load of the result. A clear request sweeps the
// valid-mark memory one bucket row a cycle. After reset the same sweep
// runs, and no request is accepted until it ends. The block holds one
// request at a time.
module hashed_key_value_table_unit #(
   parameter int BUCKETS = hkv_pkg::BUCKETS_DEFAULT,
   parameter int WAYS    = hkv_pkg::WAYS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hkv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hkv_pkg::rsp_type rsp_data
);
   import hkv_pkg::*;

   localparam int IDX = $clog2(BUCKETS);
   localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;

   state_type              state_ff, state_in;
   logic                   round_ff, round_in;
   logic [IDX-1:0]         clr_ff, clr_in;
   logic                   clr_rsp_ff, clr_rsp_in;
   logic [IDX-1:0]         bucket_ff, bucket_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   fail_ff, fail_in;
   req_type                req_ff, req_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   mix_ctl_type            mix_ctl;
   logic [63:0]            mixed;
   logic [IDX-1:0]         rd_bucket;

   logic                   rd_en;
   logic [WAYS*64-1:0]     key_rd, val_rd, key_wr, val_wr;
   logic [WAYS-1:0]        vld_rd, vld_wr;
   logic                   key_we, val_we, vld_we;
   logic [IDX-1:0]         vld_waddr;

   logic                   hit_any, free_any;
   logic [WW-1:0]          hit_idx, free_idx;

   // The mixer loads the key of the request being accepted.
   hkv_mix u_mix (
      .clock (clock),
      .ctl   (mix_ctl),
      .key   (req_data.lookup_key),
      .mixed (mixed)
   );

   // Bucket index: low bits of the final xor-shift.
   assign rd_bucket = mixed[IDX-1:0] ^ mixed[IDX+MIX_SHIFT-1:MIX_SHIFT];

   hkv_ram #(.WIDTH(WAYS*64), .DEPTH(BUCKETS)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(bucket_ff), .wr_data(key_wr),
      .rd_en(rd_en), .rd_addr(rd_bucket), .rd_data(key_rd)
   );

   hkv_ram #(.WIDTH(WAYS*64), .DEPTH(BUCKETS)) u_val_ram (
      .clock(clock), .wr_en(val_we), .wr_addr(bucket_ff), .wr_data(val_wr),
      .rd_en(rd_en), .rd_addr(rd_bucket), .rd_data(val_rd)
   );

   hkv_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_vld_ram (
      .clock(clock), .wr_en(vld_we), .wr_addr(vld_waddr), .wr_data(vld_wr),
      .rd_en(rd_en), .rd_addr(rd_bucket), .rd_data(vld_rd)
   );

   // Compare all ways of the bucket and pick the first hit and first free way.
   always_comb begin
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (vld_rd[w]) begin
            if (!hit_any && key_rd[w*64 +: 64] == req_ff.lookup_key) begin
               hit_any = 1'b1;
               hit_idx = WW'(w);
            end
         end else if (!free_any) begin
            free_any = 1'b1;
            free_idx = WW'(w);
         end
      end
   end

   // Sequencer and datapath control.
   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      bucket_in    = bucket_ff;
      cnt_in       = cnt_ff;
      fail_in      = fail_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mix_ctl      = '0;
      rd_en        = 1'b0;
      key_we       = 1'b0;
      val_we       = 1'b0;
      vld_we       = 1'b0;
      vld_waddr    = bucket_ff;
      key_wr       = key_rd;
      val_wr       = val_rd;
      vld_wr       = vld_rd;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.func == FUNC_CLEAR) begin
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = ST_CLEAR;
               end else begin
                  mix_ctl.load = 1'b1;
                  round_in     = 1'b0;
                  state_in     = ST_MUL_LO;
               end
            end
         end
         ST_MUL_LO: begin
            mix_ctl.mul_lo = 1'b1;
            state_in       = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mix_ctl.mul_hi = 1'b1;
            round_in       = 1'b1;
            state_in       = round_ff ? ST_READ : ST_MUL_LO;
         end
         ST_READ: begin
            rd_en     = 1'b1;
            bucket_in = rd_bucket;
            state_in  = ST_MATCH;
         end
         ST_MATCH: begin
            res_in                 = '0;
            res_in.found           = hit_any;
            if (hit_any) begin
               if (req_ff.func == FUNC_PUT) begin
                  val_wr[hit_idx*64 +: 64] = req_ff.store_value;
                  val_we                   = 1'b1;
               end else begin
                  res_in.read_value = val_rd[hit_idx*64 +: 64];
               end
               if (req_ff.func == FUNC_REMOVE) begin
                  vld_wr[hit_idx] = 1'b0;
                  vld_we          = 1'b1;
                  cnt_in          = cnt_ff - COUNT_WIDTH'(1);
               end
            end else if (req_ff.func == FUNC_PUT) begin
               if (free_any) begin
                  key_wr[free_idx*64 +: 64] = req_ff.lookup_key;
                  val_wr[free_idx*64 +: 64] = req_ff.store_value;
                  vld_wr[free_idx]          = 1'b1;
                  key_we                    = 1'b1;
                  val_we                    = 1'b1;
                  vld_we                    = 1'b1;
                  cnt_in                    = cnt_ff + COUNT_WIDTH'(1);
               end else begin
                  res_in.bucket_overflow = 1'b1;
                  fail_in                = 1'b1;
               end
            end
            res_in.live_entries   = cnt_in;
            res_in.sticky_failure = fail_in;
            state_in              = ST_RESP;
         end
         ST_CLEAR: begin
            vld_we    = 1'b1;
            vld_waddr = clr_ff;
            vld_wr    = '0;
            if (clr_ff == IDX'(BUCKETS - 1)) begin
               cnt_in                = '0;
               res_in                = '0;
               res_in.sticky_failure = fail_ff;
               state_in              = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end else begin
               clr_in = clr_ff + IDX'(1);
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         round_ff     <= 1'b0;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         cnt_ff       <= '0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         cnt_ff       <= cnt_in;
         fail_ff      <= fail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      bucket_ff   <= bucket_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

### hdl/hkv_checker.sv
// Port-level checks of the hashed key-value table, bound to the top level.
module hkv_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input hkv_pkg::rsp_type rsp_data
);
   import hkv_pkg::*;

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response changed.");

   // An overflow always shows in the sticky failure flag.
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bucket_overflow |-> rsp_data.sticky_failure)
      else $error("Overflow without sticky failure.");

   // A returned value comes only from a key that was found.
   a_value_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_value != 64'h0 |-> rsp_data.found)
      else $error("Value returned for an absent key.");

   // Overflow is reported only for a key that was not present.
   a_ovf_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bucket_overflow |-> !rsp_data.found)
      else $error("Overflow reported for a present key.");
endmodule

bind hashed_key_value_table_unit hkv_checker u_hkv_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### sim/tb_hashed_key_value_table_unit.sv
// Testbench for the hashed key-value table: random and directed requests checked against a predictor.
module tb_hashed_key_value_table_unit;
   import hkv_pkg::*;

   localparam int NBUCKETS = BUCKETS_DEFAULT;
   localparam int NWAYS    = WAYS_DEFAULT;
   localparam int NSLOTS   = NBUCKETS * NWAYS;
   localparam int RANDOM_REQUESTS = 1300;

   // Predicts table responses and checks them in order.
   class table_scoreboard;
      logic [63:0] keys[NSLOTS];
      logic [63:0] values[NSLOTS];
      bit          marks[NSLOTS];
      int unsigned live_count;
      bit          put_failed;
      rsp_type     pending[$];
      int          errors;

      function void reset_table();
         for (int s = 0; s < NSLOTS; s++) marks[s] = 0;
         live_count = 0;
         put_failed = 0;
         errors = 0;
         pending.delete();
      endfunction

      function logic [63:0] mix(logic [63:0] x);
         x = ((x >> MIX_SHIFT) ^ x) * 64'h45d9f3b;
         x = ((x >> MIX_SHIFT) ^ x) * 64'h45d9f3b;
         return (x >> MIX_SHIFT) ^ x;
      endfunction

      function int bucket_of(logic [63:0] key);
         return int'(mix(key) & (NBUCKETS - 1));
      endfunction

      // Apply one accepted request to the table copy and queue the response.
      function void note_request(req_type r);
         rsp_type e;
         int base, hit, free_way;
         e = '0;
         if (r.func == FUNC_CLEAR) begin
            for (int s = 0; s < NSLOTS; s++) marks[s] = 0;
            live_count = 0;
         end else begin
            base = bucket_of(r.lookup_key) * NWAYS;
            hit = -1;
            free_way = -1;
            for (int w = 0; w < NWAYS; w++) begin
               if (marks[base + w]) begin
                  if (hit < 0 && keys[base + w] == r.lookup_key) hit = w;
               end else if (free_way < 0) begin
                  free_way = w;
               end
            end
            if (hit >= 0) begin
               e.found = 1;
               if (r.func == FUNC_LOOKUP) begin
                  e.read_value = values[base + hit];
               end else if (r.func == FUNC_PUT) begin
                  values[base + hit] = r.store_value;
               end else begin
                  e.read_value = values[base + hit];
                  marks[base + hit] = 0;
                  live_count--;
               end
            end else if (r.func == FUNC_PUT) begin
               if (free_way >= 0) begin
                  keys[base + free_way] = r.lookup_key;
                  values[base + free_way] = r.store_value;
                  marks[base + free_way] = 1;
                  live_count++;
               end else begin
                  e.bucket_overflow = 1;
                  put_failed = 1;
               end
            end
         end
         e.live_entries = live_count[COUNT_WIDTH-1:0];
         e.sticky_failure = put_failed;
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %p", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.found !== e.found)
            $display("%0t: found expected %0b actual %0b", $time, e.found, got.found);
         if (got.read_value !== e.read_value)
            $display("%0t: read_value expected %h actual %h", $time, e.read_value,
                     got.read_value);
         if (got.bucket_overflow !== e.bucket_overflow)
            $display("%0t: bucket_overflow expected %0b actual %0b", $time,
                     e.bucket_overflow, got.bucket_overflow);
         if (got.live_entries !== e.live_entries)
            $display("%0t: live_entries expected %0d actual %0d", $time,
                     e.live_entries, got.live_entries);
         if (got.sticky_failure !== e.sticky_failure)
            $display("%0t: sticky_failure expected %0b actual %0b", $time,
                     e.sticky_failure, got.sticky_failure);
         if (got !== e) errors++;
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;

   table_scoreboard board = new();
   logic [63:0] used_keys[$];
   int          gap_left = 0;

   hashed_key_value_table_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // Check responses at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   // Receiver stall: randomly chosen phases of none, light and heavy stalling.
   initial begin
      int mode;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(10, 80)) begin
            @(negedge clock);
            rsp_stall <= (mode == 0) ? 1'b0 :
                         (mode == 1) ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Send one request, holding it until accepted; gaps come between bursts.
   task automatic send_request(func_type f, logic [63:0] key, logic [63:0] value);
      req_type r;
      if (gap_left == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(0, 12)) @(negedge clock);
         gap_left = $urandom_range(1, 20);
      end
      gap_left--;
      r.func = f;
      r.lookup_key = key;
      r.store_value = value;
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      used_keys.push_back(key);
      if (used_keys.size() > 64) void'(used_keys.pop_front());
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   // Pick a key that shares a bucket with a given key.
   function automatic logic [63:0] bucket_mate(logic [63:0] key);
      logic [63:0] k;
      do k = {$urandom, $urandom}; while (board.bucket_of(k) != board.bucket_of(key));
      return k;
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   initial begin
      logic [63:0] k, key;
      int pick;
      board.reset_table();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: extremes, every operation, absent keys, overwrite, overflow.
      send_request(FUNC_LOOKUP, 64'h0, 64'h0);
      send_request(FUNC_REMOVE, '1, 64'h0);
      send_request(FUNC_PUT, 64'h0, '1);
      send_request(FUNC_PUT, '1, 64'h0);
      send_request(FUNC_LOOKUP, 64'h0, 64'h0);
      send_request(FUNC_LOOKUP, '1, '1);
      send_request(FUNC_PUT, 64'h0, 64'h5555_aaaa_5555_aaaa);
      send_request(FUNC_LOOKUP, 64'h0, 64'h0);
      k = 64'h1234_5678_9abc_def0;
      send_request(FUNC_PUT, k, 64'h1);
      for (int i = 0; i < NWAYS + 1; i++) send_request(FUNC_PUT, bucket_mate(k), random_word());
      send_request(FUNC_LOOKUP, k, 64'h0);
      send_request(FUNC_REMOVE, k, 64'h0);
      send_request(FUNC_REMOVE, k, 64'h0);
      send_request(FUNC_PUT, bucket_mate(k), '1);
      send_request(FUNC_CLEAR, '1, '1);
      send_request(FUNC_LOOKUP, 64'h0, 64'h0);
      send_request(FUNC_PUT, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
      drain();

      // Random: mostly keys already seen, so hits, overwrites and removals occur.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 2) drain();
         pick = $urandom_range(0, 99);
         if (used_keys.size() != 0 && $urandom_range(0, 2) != 0)
            key = used_keys[$urandom_range(0, used_keys.size() - 1)];
         else if (used_keys.size() != 0 && $urandom_range(0, 3) == 0)
            key = bucket_mate(used_keys[$urandom_range(0, used_keys.size() - 1)]);
         else
            key = random_word();
         if (pick < 1)       send_request(FUNC_CLEAR, key, random_word());
         else if (pick < 45) send_request(FUNC_PUT, key, random_word());
         else if (pick < 75) send_request(FUNC_LOOKUP, key, random_word());
         else                send_request(FUNC_REMOVE, key, random_word());
      end

      drain();
      repeat (20) @(negedge clock);
      if (board.errors == 0)
         $display("hashed_key_value_table_unit: match");
      else
         $display("hashed_key_value_table_unit: mismatch");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #400000;
      $display("hashed_key_value_table_unit: mismatch");
      $finish;
   end

endmodule
